[rtl/rte_pkg.sv]
// ----------------------------------------------------------------------------
// rte_pkg
// Shared types, constants and the arctangent table for the rotation to Euler
// angle pipeline.
// ----------------------------------------------------------------------------
package rte_pkg;

  localparam int ANGLE_FRAC_BITS = 8;
  localparam int TABLE_FRAC      = 24;
  localparam int CORDIC_STEPS    = 26;
  localparam int SQRT_STEPS      = 32;
  localparam int NUM_W           = 41;
  localparam int CW              = 62;
  localparam int ZW              = 33;
  localparam int NORM_MSB        = 58;
  localparam int ATAN_LAT        = CORDIC_STEPS + 4;
  localparam int ANGLE_LIMIT     = 90 << ANGLE_FRAC_BITS;

  typedef struct packed {
    logic signed [15:0] m_row0_col0;
    logic signed [15:0] m_row0_col1;
    logic signed [15:0] m_row0_col2;
    logic signed [15:0] m_row1_col0;
    logic signed [15:0] m_row1_col1;
    logic signed [15:0] m_row1_col2;
    logic signed [15:0] m_row2_col0;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] yaw_deg;
    logic signed [15:0] pitch_deg;
    logic signed [15:0] roll_deg;
  } out_item_t;

  // atan(2^-i) in units of 2^-24 degree
  function automatic logic signed [ZW-1:0] atan_entry(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 33'sd754974720;
      1:  v = 33'sd445687602;
      2:  v = 33'sd235489088;
      3:  v = 33'sd119537938;
      4:  v = 33'sd60000934;
      5:  v = 33'sd30029717;
      6:  v = 33'sd15018523;
      7:  v = 33'sd7509720;
      8:  v = 33'sd3754917;
      9:  v = 33'sd1877466;
      10: v = 33'sd938734;
      11: v = 33'sd469367;
      12: v = 33'sd234684;
      13: v = 33'sd117342;
      14: v = 33'sd58671;
      15: v = 33'sd29335;
      16: v = 33'sd14668;
      17: v = 33'sd7334;
      18: v = 33'sd3667;
      19: v = 33'sd1833;
      20: v = 33'sd917;
      21: v = 33'sd458;
      22: v = 33'sd229;
      23: v = 33'sd115;
      24: v = 33'sd57;
      25: v = 33'sd29;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/rte_isqrt.sv]
// ----------------------------------------------------------------------------
// rte_isqrt
// Pipelined integer square root of (sum << 32), one result bit per stage.
// ----------------------------------------------------------------------------
module rte_isqrt
  import rte_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] sum_i,
  output logic [31:0] root_o
);

  logic [63:0] v_r [SQRT_STEPS];
  logic [63:0] q_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
    logic [63:0] v_in, q_in, v_nxt, q_nxt, bitv;
    logic [64:0] trial;

    always_comb begin
      v_in  = (k == 0) ? {sum_i, 32'd0} : v_r[(k == 0) ? 0 : k - 1];
      q_in  = (k == 0) ? 64'd0 : q_r[(k == 0) ? 0 : k - 1];
      bitv  = 64'd1 << (62 - 2 * k);
      trial = {1'b0, q_in} + {1'b0, bitv};
      if ({1'b0, v_in} >= trial) begin
        v_nxt = v_in - trial[63:0];
        q_nxt = (q_in >> 1) + bitv;
      end else begin
        v_nxt = v_in;
        q_nxt = q_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[k] <= v_nxt;
        q_r[k] <= q_nxt;
      end
    end
  end

  assign root_o = q_r[SQRT_STEPS-1][31:0];

endmodule

[rtl/rte_atan.sv]
// ----------------------------------------------------------------------------
// rte_atan
// Pipelined arctangent of num/den in degrees: normalize, vectoring CORDIC,
// round and clamp.
// ----------------------------------------------------------------------------
module rte_atan
  import rte_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic signed [NUM_W-1:0] den_i,
  output logic [15:0]             ang_o
);

  localparam int DL = CORDIC_STEPS + 3;
  localparam logic signed [ZW-1:0] LIM = ZW'(ANGLE_LIMIT);
  localparam logic signed [ZW-1:0] RND = ZW'(1) << (TABLE_FRAC - 1 - ANGLE_FRAC_BITS);

  logic             spec_d  [DL];
  logic [15:0]      specv_d [DL];
  logic             yneg_d  [2];

  logic [NUM_W-1:0] mx0_r, my0_r, mx1_r, my1_r;
  logic [5:0]       sh1_r;
  logic signed [CW-1:0] x_r [CORDIC_STEPS+1];
  logic signed [CW-1:0] y_r [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_r [CORDIC_STEPS+1];

  // Stage 0: fold the denominator sign, take magnitudes, flag special cases
  logic signed [NUM_W-1:0] n2, d2;
  logic                    spec0;
  logic [15:0]             specv0;
  always_comb begin
    d2     = den_i[NUM_W-1] ? -den_i : den_i;
    n2     = den_i[NUM_W-1] ? -num_i : num_i;
    spec0  = (num_i == '0) || (den_i == '0);
    specv0 = (num_i == '0) ? 16'd0 :
             (num_i > 0) ? LIM[15:0] : 16'(-LIM);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx0_r     <= d2;
      my0_r     <= n2[NUM_W-1] ? NUM_W'(-n2) : NUM_W'(n2);
      yneg_d[0] <= n2[NUM_W-1];
    end
  end

  // Stage 1: find the shift that brings the larger magnitude to 2^58
  logic [NUM_W-1:0] big;
  logic [5:0]       msb;
  always_comb begin
    big = (mx0_r > my0_r) ? mx0_r : my0_r;
    msb = '0;
    for (int j = 0; j < NUM_W; j++) begin
      if (big[j]) msb = 6'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx1_r     <= mx0_r;
      my1_r     <= my0_r;
      sh1_r     <= 6'(NORM_MSB) - msb;
      yneg_d[1] <= yneg_d[0];
    end
  end

  // Stage 2: apply the shift
  logic signed [CW-1:0] xs, ys;
  always_comb begin
    xs = CW'(mx1_r) << sh1_r;
    ys = CW'(my1_r) << sh1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= xs;
      y_r[0] <= yneg_d[1] ? -ys : ys;
      z_r[0] <= '0;
    end
  end

  // CORDIC micro-rotations, one per stage
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    logic signed [CW-1:0] dx, dy;
    assign dx = y_r[k] >>> k;
    assign dy = x_r[k] >>> k;
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[k] > 0) begin
          x_r[k+1] <= x_r[k] + dx;
          y_r[k+1] <= y_r[k] - dy;
          z_r[k+1] <= z_r[k] + atan_entry(k);
        end else begin
          x_r[k+1] <= x_r[k] - dx;
          y_r[k+1] <= y_r[k] + dy;
          z_r[k+1] <= z_r[k] - atan_entry(k);
        end
      end
    end
  end

  // Carry the special-case flag alongside the data
  always_ff @(posedge clk) begin
    if (en) begin
      spec_d[0]  <= spec0;
      specv_d[0] <= specv0;
      for (int i = 1; i < DL; i++) begin
        spec_d[i]  <= spec_d[i-1];
        specv_d[i] <= specv_d[i-1];
      end
    end
  end

  // Round to the output fraction, ties up, and clamp to +-90 degrees
  logic signed [ZW-1:0] rz, rr;
  always_comb begin
    rz = (z_r[CORDIC_STEPS] + RND) >>> (TABLE_FRAC - ANGLE_FRAC_BITS);
    rr = rz;
    if (rz > LIM)  rr = LIM;
    if (rz < -LIM) rr = -LIM;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_o <= spec_d[DL-1] ? specv_d[DL-1] : rr[15:0];
    end
  end

endmodule

[rtl/rotation_to_euler_angles.sv]
// ----------------------------------------------------------------------------
// rotation_to_euler_angles
// Z-Y-X Euler angles (yaw, pitch, roll) in degrees from a rotation matrix.
// ----------------------------------------------------------------------------
// Pipeline: 63 register stages (1 product stage, 32 square-root stages,
//   30 arctangent stages).
// Throughput: one item per cycle; the whole pipeline holds while a result
//   waits at the output register.
// Reset: rst_n synchronous, active low; clears all valid bits.
// ----------------------------------------------------------------------------
module rotation_to_euler_angles
  import rte_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int LAT = 1 + SQRT_STEPS + ATAN_LAT;

  // Valid bits travel with the data; the pipeline advances as one
  logic [LAT-1:0] vld_r;
  logic           en;

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Stage 1: direction of yaw as an integer vector (c, s), squared norm,
  // roll terms and pitch numerator.
  logic signed [16:0] c, s;
  logic signed [32:0] sq;
  logic signed [33:0] rnum_nxt, rden_nxt;
  logic signed [33:0] pnum_nxt;
  logic               r00_neg;

  always_comb begin
    r00_neg = in_data.m_row0_col0[15];
    if (in_data.m_row0_col0 == '0 && in_data.m_row1_col0 == '0) begin
      c = 17'sd1;
      s = 17'sd0;
    end else if (r00_neg) begin
      c = -17'(in_data.m_row0_col0);
      s = -17'(in_data.m_row1_col0);
    end else begin
      c = 17'(in_data.m_row0_col0);
      s = 17'(in_data.m_row1_col0);
    end
    sq = 33'(in_data.m_row0_col0) * 33'(in_data.m_row0_col0)
       + 33'(in_data.m_row1_col0) * 33'(in_data.m_row1_col0);
    rnum_nxt = 34'(in_data.m_row0_col2) * 34'(s) - 34'(in_data.m_row1_col2) * 34'(c);
    rden_nxt = 34'(in_data.m_row1_col1) * 34'(c) - 34'(in_data.m_row0_col1) * 34'(s);
    pnum_nxt = -(34'(in_data.m_row2_col0) <<< 16);
  end

  logic [31:0]        sum_r;
  logic signed [15:0] r00_r, r10_r;
  logic signed [33:0] rnum_r, rden_r, pnum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r  <= sq[31:0];
      r00_r  <= in_data.m_row0_col0;
      r10_r  <= in_data.m_row1_col0;
      rnum_r <= rnum_nxt;
      rden_r <= rden_nxt;
      pnum_r <= pnum_nxt;
    end
  end

  // Norm of (r00, r10), scaled by 2^16
  logic [31:0] mag;

  rte_isqrt u_isqrt (
    .clk    (clk),
    .en     (en),
    .sum_i  (sum_r),
    .root_o (mag)
  );

  // Hold the other operands alongside the square-root pipeline
  logic signed [15:0] r00_d  [SQRT_STEPS];
  logic signed [15:0] r10_d  [SQRT_STEPS];
  logic signed [33:0] rnum_d [SQRT_STEPS];
  logic signed [33:0] rden_d [SQRT_STEPS];
  logic signed [33:0] pnum_d [SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      r00_d[0]  <= r00_r;
      r10_d[0]  <= r10_r;
      rnum_d[0] <= rnum_r;
      rden_d[0] <= rden_r;
      pnum_d[0] <= pnum_r;
      for (int i = 1; i < SQRT_STEPS; i++) begin
        r00_d[i]  <= r00_d[i-1];
        r10_d[i]  <= r10_d[i-1];
        rnum_d[i] <= rnum_d[i-1];
        rden_d[i] <= rden_d[i-1];
        pnum_d[i] <= pnum_d[i-1];
      end
    end
  end

  // Pitch denominator takes the sign of r00
  logic signed [NUM_W-1:0] pden;
  assign pden = r00_d[SQRT_STEPS-1][15] ? -NUM_W'(mag) : NUM_W'(mag);

  logic [15:0] yaw, pitch, roll;

  rte_atan u_atan_yaw (
    .clk   (clk),
    .en    (en),
    .num_i (NUM_W'(r10_d[SQRT_STEPS-1])),
    .den_i (NUM_W'(r00_d[SQRT_STEPS-1])),
    .ang_o (yaw)
  );

  rte_atan u_atan_pitch (
    .clk   (clk),
    .en    (en),
    .num_i (NUM_W'(pnum_d[SQRT_STEPS-1])),
    .den_i (pden),
    .ang_o (pitch)
  );

  rte_atan u_atan_roll (
    .clk   (clk),
    .en    (en),
    .num_i (NUM_W'(rnum_d[SQRT_STEPS-1])),
    .den_i (NUM_W'(rden_d[SQRT_STEPS-1])),
    .ang_o (roll)
  );

  assign out_data.yaw_deg   = yaw;
  assign out_data.pitch_deg = pitch;
  assign out_data.roll_deg  = roll;

endmodule

[rtl/rte_checker.sv]
// ----------------------------------------------------------------------------
// rte_checker
// Port-level checks for the Euler angle pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module rte_checker
  import rte_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  localparam logic signed [15:0] LIM = 16'(ANGLE_LIMIT);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("stalled input item dropped or changed");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.yaw_deg <= LIM && out_data.yaw_deg >= -LIM
      && out_data.pitch_deg <= LIM && out_data.pitch_deg >= -LIM
      && out_data.roll_deg <= LIM && out_data.roll_deg >= -LIM)
    else $error("angle beyond 90 degrees");

endmodule

bind rotation_to_euler_angles rte_checker u_rte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rotation_to_euler_angles: random and corner-case
// matrices go in through a stalling driver, a bit-true model of the CORDIC
// angle pipeline predicts each result, and the monitor compares in order.
// ----------------------------------------------------------------------------
module tb;
  import rte_pkg::*;

  localparam int PIPE_LAT   = 63;
  localparam int WDOG_LIMIT = 20000;
  localparam int N_RANDOM   = 1330;
  localparam int HOLD_LEN   = 400;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  rotation_to_euler_angles u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  in_item_t  matrix_q[$];
  out_item_t angles_q[$];
  int        errors = 0;
  bit        stim_done;
  // Long receiver hold-off, requested by the driver and counted by the monitor.
  bit        hold_req;
  // Sender pause: the driver waits until every pending result has drained.
  bit        drain_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // atan(2^-i) in 2^-24 degree, rounded to nearest
  longint atan_table[CORDIC_STEPS] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

  // Arithmetic shift right that rounds toward minus infinity.
  function automatic longint shr_floor(longint v, int sh);
    return v >>> sh;
  endfunction

  function automatic longint isqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bt;
    res = 0;
    bt  = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt >>= 2;
    end
    return longint'(res);
  endfunction

  // Vectoring CORDIC arctangent, degrees with ANGLE_FRAC_BITS fraction bits.
  function automatic longint atan_fixed(longint num, longint den);
    longint lim;
    longint x, y, z, r, dx, dy;
    longint unsigned mx, my, big;
    bit yneg;
    lim = longint'(90) << ANGLE_FRAC_BITS;
    if (num == 0) return 0;
    if (den == 0) return (num > 0) ? lim : -lim;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    yneg = num < 0;
    mx   = den;
    my   = yneg ? -num : num;
    big  = (mx > my) ? mx : my;
    while (big < (64'd1 << 58)) begin
      big <<= 1;
      mx  <<= 1;
      my  <<= 1;
    end
    x = mx;
    y = yneg ? -longint'(my) : longint'(my);
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += longint'(atan_table[i]);
      end else begin
        x -= dx;
        y += dy;
        z -= longint'(atan_table[i]);
      end
    end
    r = shr_floor(z + (longint'(1) << (TABLE_FRAC - 1 - ANGLE_FRAC_BITS)),
                  TABLE_FRAC - ANGLE_FRAC_BITS);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic out_item_t euler_of(in_item_t m);
    longint r00, r01, r02, r10, r11, r12, r20, c, s, pden, mag;
    out_item_t o;
    r00 = m.m_row0_col0; r01 = m.m_row0_col1; r02 = m.m_row0_col2;
    r10 = m.m_row1_col0; r11 = m.m_row1_col1; r12 = m.m_row1_col2;
    r20 = m.m_row2_col0;
    o.yaw_deg = 16'(atan_fixed(r10, r00));
    // Carry yaw direction as a vector; undefined yaw means cos 1, sin 0.
    if (r00 == 0 && r10 == 0) begin
      c = 1; s = 0;
    end else if (r00 < 0) begin
      c = -r00; s = -r10;
    end else begin
      c = r00; s = r10;
    end
    mag  = isqrt(longint'(r00 * r00 + r10 * r10) << 32);
    pden = (r00 < 0) ? -mag : mag;
    o.pitch_deg = 16'(atan_fixed(-r20 * 65536, pden));
    o.roll_deg  = 16'(atan_fixed(r02 * s - r12 * c, r11 * c - r01 * s));
    return o;
  endfunction

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 9))
      0:       return 16'sd16384;
      1:       return -16'sd16384;
      2:       return 16'sd0;
      3:       return 16'($urandom_range(0, 65535));  // any bit pattern
      4:       return 16'($signed($urandom_range(0, 16)) - 8);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic in_item_t mk(int a, int b, int c2, int d, int e, int f, int g);
    in_item_t m;
    m.m_row0_col0 = 16'(a); m.m_row0_col1 = 16'(b); m.m_row0_col2 = 16'(c2);
    m.m_row1_col0 = 16'(d); m.m_row1_col1 = 16'(e); m.m_row1_col2 = 16'(f);
    m.m_row2_col0 = 16'(g);
    return m;
  endfunction

  // Stimulus: directed corners first, then random matrices.
  initial begin
    in_item_t m;
    stim_done = 1'b0;
    // identity, zero matrix, undefined yaw, zero denominators, extremes
    matrix_q.push_back(mk(16384, 0, 0, 0, 16384, 0, 0));
    matrix_q.push_back(mk(0, 0, 0, 0, 0, 0, 0));
    matrix_q.push_back(mk(0, 0, 16384, 0, 16384, 0, -16384));
    matrix_q.push_back(mk(0, 0, 0, 0, 0, 0, 16384));
    matrix_q.push_back(mk(0, 16384, 0, 16384, 0, 0, 0));
    matrix_q.push_back(mk(0, -16384, 0, -16384, 0, 0, 0));
    matrix_q.push_back(mk(-16384, 0, 0, 0, -16384, 0, 0));
    matrix_q.push_back(mk(-16384, 16384, 16384, 16384, 16384, -16384, 16384));
    matrix_q.push_back(mk(16384, -16384, -16384, -16384, -16384, 16384, -16384));
    matrix_q.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    matrix_q.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    matrix_q.push_back(mk(11585, -11585, 0, 11585, 11585, 0, 0));
    matrix_q.push_back(mk(1, 0, 1, 1, 0, -1, 1));
    matrix_q.push_back(mk(-1, 1, 0, -1, 1, 0, -1));
    matrix_q.push_back(mk(16384, 0, 0, 0, 0, 16384, 0));
    matrix_q.push_back(mk(16384, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < N_RANDOM; i++) begin
      m.m_row0_col0 = rand_elem(); m.m_row0_col1 = rand_elem();
      m.m_row0_col2 = rand_elem(); m.m_row1_col0 = rand_elem();
      m.m_row1_col1 = rand_elem(); m.m_row1_col2 = rand_elem();
      m.m_row2_col0 = rand_elem();
      matrix_q.push_back(m);
    end
    stim_done = 1'b1;
  end

  // Driver: pop pending matrices, insert random gaps, honor drain pauses.
  int  gap_cnt;
  int  sent_cnt;
  always @(posedge clk) begin
    in_item_t nxt_m;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      gap_cnt   <= 0;
      sent_cnt  <= 0;
      hold_req  <= 1'b0;
      drain_req <= 1'b0;
    end else if (in_valid && !in_ready) begin
      // hold the item until accepted
    end else begin
      if (in_valid) sent_cnt <= sent_cnt + 1;
      if (in_valid && sent_cnt == 299) hold_req <= 1'b1;
      if (in_valid && sent_cnt == 599) begin
        drain_req <= 1'b1;
      end else if (drain_req && angles_q.size() == 0) begin
        drain_req <= 1'b0;
      end
      if (gap_cnt > 0 || drain_req || (in_valid && sent_cnt == 599) ||
          matrix_q.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_cnt > 0) gap_cnt <= gap_cnt - 1;
      end else begin
        nxt_m = matrix_q.pop_front();
        in_data  <= nxt_m;
        in_valid <= 1'b1;
        // stretches with no gaps between bursts
        gap_cnt  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        angles_q.push_back(euler_of(nxt_m));
      end
    end
  end

  // Monitor: random back-pressure, compare every accepted result in order.
  int stall_cnt;
  int hold_cnt;
  bit hold_done;
  always @(posedge clk) begin
    out_item_t exp_o;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_cnt <= 0;
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (angles_q.size() == 0) begin
          $display("%0t: unexpected result exp none act %h", $time, out_data);
          errors++;
        end else begin
          exp_o = angles_q.pop_front();
          if (out_data.yaw_deg !== exp_o.yaw_deg) begin
            $display("%0t: yaw exp %0d act %0d", $time, exp_o.yaw_deg, out_data.yaw_deg);
            errors++;
          end
          if (out_data.pitch_deg !== exp_o.pitch_deg) begin
            $display("%0t: pitch exp %0d act %0d", $time, exp_o.pitch_deg,
                     out_data.pitch_deg);
            errors++;
          end
          if (out_data.roll_deg !== exp_o.roll_deg) begin
            $display("%0t: roll exp %0d act %0d", $time, exp_o.roll_deg,
                     out_data.roll_deg);
            errors++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        // long hold-off so the pipeline fills and stalls its input
        out_ready <= 1'b0;
        hold_cnt  <= HOLD_LEN;
        hold_done <= 1'b1;
      end else if (hold_cnt > 0) begin
        out_ready <= 1'b0;
        hold_cnt  <= hold_cnt - 1;
      end else if (stall_cnt > 0) begin
        out_ready <= 1'b0;
        stall_cnt <= stall_cnt - 1;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready)
          stall_cnt <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      end
    end
  end

  // Reset, watchdog and end of run.
  initial begin
    int idle;
    rst_n  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    idle = 0;
    while (!(stim_done && matrix_q.size() == 0 && !in_valid && angles_q.size() == 0)) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
      if (idle >= WDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
    repeat (PIPE_LAT + 20) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
